/* design/calendar_clock_second_tick_unit_macros.svh */
// Assertion macros shared by the calendar clock RTL
`ifndef CALENDAR_CLOCK_SECOND_TICK_UNIT_MACROS_SVH
`define CALENDAR_CLOCK_SECOND_TICK_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CCST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CCST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ccst_pkg.sv */
// Types, constants and month table for the calendar clock
`default_nettype none
package ccst_pkg;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    localparam logic [5:0] SEC_PER_MIN  = 6'd60;
    localparam logic [5:0] MIN_PER_HOUR = 6'd60;
    localparam logic [4:0] HOUR_PER_DAY = 5'd24;
    localparam logic [4:0] MONTH_LIMIT  = 5'd13;
    localparam logic [3:0] MONTH_FEB    = 4'd2;

    localparam logic [15:0] RESET_YEAR  = 16'd2026;
    localparam logic [3:0]  RESET_MONTH = 4'd1;
    localparam logic [4:0]  RESET_DAY   = 5'd1;

    // 25 * INV25 == 1 mod 2^16; y is a multiple of 25 iff y*INV25 mod 2^16 <= DIV25_MAX
    localparam logic [15:0] INV25     = 16'h5C29;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    typedef struct packed {
        logic        action;
        logic [15:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
    } item_t;

    typedef struct packed {
        logic [15:0] year_now;
        logic [3:0]  month_now;
        logic [4:0]  day_now;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic [5:0]  second_now;
        logic        new_minute;
    } result_t;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    // month length; codes with no meaning count as 31 days
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        case (month)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

/* design/ccst_item_if.sv */
// Valid/ready channel carrying input items
`default_nettype none
interface ccst_item_if
    import ccst_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* design/ccst_result_if.sv */
// Valid/ready channel carrying result items
`default_nettype none
interface ccst_result_if
    import ccst_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* design/ccst_leap.sv */
// Gregorian leap-year detect for a 16-bit year
`default_nettype none
module ccst_leap
    import ccst_pkg::*;
(
    input  wire logic [15:0] year,
    output logic             leap
);
    logic [15:0] prod;
    logic        div25;

    always_comb
    begin
        prod  = year * INV25;
        div25 = (prod <= DIV25_MAX);
        // multiple of 4, and either not of 100 or also of 400 (= 16 * 25)
        leap  = (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
    end
endmodule
`default_nettype wire

/* design/ccst_advance.sv */
// Next calendar state for one item: load or one-second carry chain
`default_nettype none
module ccst_advance
    import ccst_pkg::*;
(
    input  wire calendar_t cur,
    input  wire item_t     item,
    output calendar_t      nxt,
    output logic           wrapped
);
    logic       leap;
    logic [6:0] s_inc;
    logic [6:0] mi_inc;
    logic [5:0] h_inc;
    logic [5:0] d_inc;
    logic [4:0] mo_inc;

    ccst_leap u_leap (
        .year (cur.year),
        .leap (leap)
    );

    always_comb
    begin
        s_inc   = {1'b0, cur.second} + 7'd1;
        mi_inc  = {1'b0, cur.minute} + 7'd1;
        h_inc   = {1'b0, cur.hour} + 6'd1;
        d_inc   = {1'b0, cur.day} + 6'd1;
        mo_inc  = {1'b0, cur.month} + 5'd1;
        nxt     = cur;
        wrapped = 1'b0;
        if (item.action == ACT_LOAD)
        begin
            nxt.year   = item.load_year;
            nxt.month  = item.load_month;
            nxt.day    = item.load_day;
            nxt.hour   = item.load_hour;
            nxt.minute = item.load_minute;
            nxt.second = item.load_second;
        end
        else if (s_inc < {1'b0, SEC_PER_MIN})
        begin
            nxt.second = s_inc[5:0];
        end
        else
        begin
            nxt.second = 6'd0;
            wrapped    = 1'b1;
            if (mi_inc < {1'b0, MIN_PER_HOUR})
            begin
                nxt.minute = mi_inc[5:0];
            end
            else
            begin
                nxt.minute = 6'd0;
                if (h_inc < {1'b0, HOUR_PER_DAY})
                begin
                    nxt.hour = h_inc[4:0];
                end
                else
                begin
                    nxt.hour = 5'd0;
                    if (d_inc <= {1'b0, month_days(cur.month, leap)})
                    begin
                        nxt.day = d_inc[4:0];
                    end
                    else
                    begin
                        // day wraps to 1; month 0 just becomes 1, 12 and up carry a year
                        nxt.day = 5'd1;
                        if (mo_inc < MONTH_LIMIT)
                        begin
                            nxt.month = mo_inc[3:0];
                        end
                        else
                        begin
                            nxt.month = 4'd1;
                            nxt.year  = cur.year + 16'd1;
                        end
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* design/calendar_clock_second_tick_unit.sv */
// Top level of the calendar clock: input register, calendar state, result register
//
// Calendar counter with Gregorian leap years. Each req item is either a one-second
// tick (action 0) or a load of the full date and time (action 1, values not checked).
// Every item returns one rsp item with the date and time after it and a flag set
// when a tick wrapped the seconds to zero. Throughput is one item per clock while rsp
// is not stalled: the carry chain and the leap-year test (one 16x16 multiply) sit between
// the input register and the result register, and the calendar state updates in the same
// cycle. rsp valid rises when the item moves from the input register into the result
// register; a stalled rsp holds the item in the input register. Reset date is
// 2026-01-01 00:00:00.
`default_nettype none
`include "calendar_clock_second_tick_unit_macros.svh"
module calendar_clock_second_tick_unit
    import ccst_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ccst_item_if.sink     req,
    ccst_result_if.source rsp
);
    item_t     item_reg;
    logic      in_valid_reg;
    calendar_t cal_reg;
    calendar_t cal_next;
    result_t   result_reg;
    result_t   result_next;
    logic      out_valid_reg;
    logic      wrapped;
    logic      out_free;
    logic      stage_fire;
    logic      req_fire;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign stage_fire = in_valid_reg && out_free;
    assign req.ready  = !in_valid_reg || out_free;
    assign req_fire   = req.valid && req.ready;

    ccst_advance u_advance (
        .cur     (cal_reg),
        .item    (item_reg),
        .nxt     (cal_next),
        .wrapped (wrapped)
    );

    always_comb
    begin
        result_next.year_now   = cal_next.year;
        result_next.month_now  = cal_next.month;
        result_next.day_now    = cal_next.day;
        result_next.hour_now   = cal_next.hour;
        result_next.minute_now = cal_next.minute;
        result_next.second_now = cal_next.second;
        result_next.new_minute = wrapped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cal_reg.year   <= RESET_YEAR;
            cal_reg.month  <= RESET_MONTH;
            cal_reg.day    <= RESET_DAY;
            cal_reg.hour   <= 5'd0;
            cal_reg.minute <= 6'd0;
            cal_reg.second <= 6'd0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (stage_fire)
            begin
                cal_reg <= cal_next;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg <= req.payload;
        end
        if (stage_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = result_reg;

    `CCST_ASSERT_NEXT(a_stage_fills_out, stage_fire, out_valid_reg, "item lost at result register")
    `CCST_ASSERT_NOW(a_hold_when_blocked, in_valid_reg && !out_free, !req.ready,
        "input register overwritten while blocked")
    `CCST_ASSERT_NOW(a_out_tracks_state, out_valid_reg,
        result_reg.second_now == cal_reg.second && result_reg.year_now == cal_reg.year,
        "result register out of step with calendar state")
    `CCST_ASSERT_NEXT(a_tick_moves_second, stage_fire && item_reg.action == ACT_TICK,
        cal_reg.second != $past(cal_reg.second), "tick left seconds unchanged")
    `CCST_ASSERT_NOW(a_wrap_zero_second, stage_fire && wrapped,
        cal_next.second == 6'd0 && item_reg.action == ACT_TICK, "new minute without second wrap")
endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the calendar clock: directed date cases, then random tick/load runs
module testbench;
    import ccst_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 475;
    localparam int DRAIN_CYCLES    = 10;

    typedef struct packed {
        item_t   stim;
        logic    typed;
        result_t want;
    } date_case_t;

    typedef struct packed {
        logic    typed;
        result_t want;
    } pin_t;

    logic clk;
    logic rst_n;

    ccst_item_if   req_ch ();
    ccst_result_if rsp_ch ();

    calendar_clock_second_tick_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    calendar_t  cal;
    result_t    pending_dates [$];
    pin_t       pinned_q [$];
    date_case_t date_cases [$];
    int         mismatch_count;
    int         idle_pct;
    int         stall_pct;
    int         quiet_cycles;

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic bit leap_year(input logic [15:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in(input logic [3:0] m, input logic [15:0] y);
        case (m)
            MONTH_FEB:                return leap_year(y) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            default:                  return 31;
        endcase
    endfunction

    // advance the shadow calendar by one item and return the date it shows
    function automatic result_t calendar_after(input item_t it);
        int unsigned s, mi, h, d, mo;
        logic        wrapped;
        wrapped = 1'b0;
        if (it.action == ACT_LOAD)
        begin
            cal.year   = it.load_year;
            cal.month  = it.load_month;
            cal.day    = it.load_day;
            cal.hour   = it.load_hour;
            cal.minute = it.load_minute;
            cal.second = it.load_second;
        end
        else
        begin
            s = cal.second + 1;
            if (s >= SEC_PER_MIN)
            begin
                s = 0;
                wrapped = 1'b1;
                mi = cal.minute + 1;
                if (mi >= MIN_PER_HOUR)
                begin
                    mi = 0;
                    h = cal.hour + 1;
                    if (h >= HOUR_PER_DAY)
                    begin
                        h = 0;
                        d = cal.day + 1;
                        if (d > days_in(cal.month, cal.year))
                        begin
                            d = 1;
                            mo = cal.month + 1;
                            // month codes past December wrap into the next year
                            if (mo >= MONTH_LIMIT)
                            begin
                                mo = 1;
                                cal.year = cal.year + 16'd1;
                            end
                            cal.month = mo[3:0];
                        end
                        cal.day = d[4:0];
                    end
                    cal.hour = h[4:0];
                end
                cal.minute = mi[5:0];
            end
            cal.second = s[5:0];
        end
        return '{cal.year, cal.month, cal.day, cal.hour, cal.minute, cal.second, wrapped};
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_date(input result_t want, input result_t got);
        check_field("year_now",   want.year_now,   got.year_now);
        check_field("month_now",  want.month_now,  got.month_now);
        check_field("day_now",    want.day_now,    got.day_now);
        check_field("hour_now",   want.hour_now,   got.hour_now);
        check_field("minute_now", want.minute_now, got.minute_now);
        check_field("second_now", want.second_now, got.second_now);
        check_field("new_minute", want.new_minute, got.new_minute);
    endfunction

    function automatic item_t load_item(input int y, input int mo, input int d, input int h,
                                        input int mi, input int s);
        return '{ACT_LOAD, 16'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s)};
    endfunction

    function automatic item_t tick_item();
        return '{ACT_TICK, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0};
    endfunction

    function automatic result_t cal_result(input int y, input int mo, input int d, input int h,
                                           input int mi, input int s, input int nm);
        return '{16'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s), 1'(nm)};
    endfunction

    // random load fields; near_rollover puts the date a few ticks from a carry
    function automatic item_t random_item(input bit near_rollover);
        item_t it;
        it.action      = ACT_LOAD;
        it.load_year   = 16'($urandom);
        it.load_month  = 4'($urandom);
        it.load_day    = 5'($urandom);
        it.load_hour   = 5'($urandom);
        it.load_minute = 6'($urandom);
        it.load_second = 6'($urandom);
        if (near_rollover)
        begin
            case ($urandom_range(5))
                0:       it.load_year = 16'($urandom & 32'hFFFC);
                1:       it.load_year = 16'(100 * $urandom_range(655));
                2:       it.load_year = 16'(400 * $urandom_range(163));
                3:       it.load_year = 16'hFFFF;
                4:       it.load_year = 16'($urandom_range(2100, 1900));
                default: ;
            endcase
            if ($urandom_range(9) != 0)
                it.load_month = 4'($urandom_range(12, 1));
            if ($urandom_range(3) != 0)
                it.load_day = 5'(days_in(it.load_month, it.load_year) - $urandom_range(1));
            if ($urandom_range(4) != 0)
                it.load_hour = 5'd23;
            if ($urandom_range(4) != 0)
                it.load_minute = 6'd59;
            it.load_second = 6'($urandom_range(63, 50));
        end
        return it;
    endfunction

    // drive one item at the falling edge and hold it until accepted
    task automatic send_item(input item_t it, input logic typed, input result_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pinned_q.push_back('{typed, want});
        req_ch.valid   <= 1'b1;
        req_ch.payload <= it;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_ticks(input int count);
        item_t it;
        for (int i = 0; i < count; i++)
        begin
            it = random_item(1'b0);
            it.action = ACT_TICK;
            send_item(it, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        pin_t    pin;
        result_t next_date;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                next_date = calendar_after(req_ch.payload);
                pin = pinned_q.pop_front();
                pending_dates.push_back(pin.typed ? pin.want : next_date);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                if (pending_dates.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected, got %p", $time, rsp_ch.payload);
                end
                else
                    check_date(pending_dates.pop_front(), rsp_ch.payload);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int sent;
        int kind;
        int n;
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        cal = '{RESET_YEAR, RESET_MONTH, RESET_DAY, 5'd0, 6'd0, 6'd0};

        // first tick from the reset date, then leap rules, wraps and unchecked loads
        date_cases.push_back('{tick_item(), 1'b1, cal_result(2026, 1, 1, 0, 0, 1, 0)});
        date_cases.push_back('{load_item(2024, 2, 28, 23, 59, 59), 1'b1,
                               cal_result(2024, 2, 28, 23, 59, 59, 0)});
        date_cases.push_back('{tick_item(), 1'b1, cal_result(2024, 2, 29, 0, 0, 0, 1)});
        date_cases.push_back('{load_item(2100, 2, 28, 23, 59, 59), 1'b0, '0});
        date_cases.push_back('{tick_item(), 1'b1, cal_result(2100, 3, 1, 0, 0, 0, 1)});
        date_cases.push_back('{load_item(2000, 2, 28, 23, 59, 59), 1'b0, '0});
        date_cases.push_back('{tick_item(), 1'b1, cal_result(2000, 2, 29, 0, 0, 0, 1)});
        date_cases.push_back('{load_item(2023, 2, 28, 23, 59, 59), 1'b0, '0});
        date_cases.push_back('{tick_item(), 1'b1, cal_result(2023, 3, 1, 0, 0, 0, 1)});
        date_cases.push_back('{load_item(65535, 12, 31, 23, 59, 59), 1'b0, '0});
        date_cases.push_back('{tick_item(), 1'b1, cal_result(0, 1, 1, 0, 0, 0, 1)});
        date_cases.push_back('{load_item(0, 0, 0, 31, 63, 63), 1'b1,
                               cal_result(0, 0, 0, 31, 63, 63, 0)});
        date_cases.push_back('{tick_item(), 1'b0, '0});
        date_cases.push_back('{load_item(65535, 15, 31, 31, 63, 63), 1'b1,
                               cal_result(65535, 15, 31, 31, 63, 63, 0)});
        date_cases.push_back('{tick_item(), 1'b1, cal_result(0, 1, 1, 0, 0, 0, 1)});
        date_cases.push_back('{load_item(1234, 13, 31, 23, 59, 59), 1'b0, '0});
        date_cases.push_back('{tick_item(), 1'b0, '0});
        date_cases.push_back('{load_item(2026, 4, 31, 23, 59, 59), 1'b0, '0});
        date_cases.push_back('{tick_item(), 1'b0, '0});
        date_cases.push_back('{load_item(2026, 4, 30, 23, 59, 58), 1'b0, '0});
        date_cases.push_back('{tick_item(), 1'b0, '0});
        date_cases.push_back('{tick_item(), 1'b0, '0});
        date_cases.push_back('{load_item(1999, 7, 4, 5, 59, 59), 1'b0, '0});
        date_cases.push_back('{tick_item(), 1'b0, '0});
        date_cases.push_back('{load_item(2026, 0, 31, 23, 59, 59), 1'b0, '0});
        date_cases.push_back('{tick_item(), 1'b0, '0});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (date_cases[i])
            send_item(date_cases[i].stim, date_cases[i].typed, date_cases[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 55; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                kind = $urandom_range(99);
                if (kind < 55)
                begin
                    n = $urandom_range(12, 1);
                    send_item(random_item(1'b1), 1'b0, '0);
                end
                else if (kind < 70)
                begin
                    n = $urandom_range(4, 1);
                    send_item(random_item(1'b0), 1'b0, '0);
                end
                else
                begin
                    n = $urandom_range(20, 1);
                    sent--;
                end
                send_ticks(n);
                sent += n + 1;
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* calendar_clock_second_tick_unit.f */
+incdir+design
design/ccst_pkg.sv
design/ccst_item_if.sv
design/ccst_result_if.sv
design/ccst_leap.sv
design/ccst_advance.sv
design/calendar_clock_second_tick_unit.sv
sim/testbench.sv
